// ===== rtl/core/asgr_pkg.sv =====
// shared types, codes, colour tables and helpers of the terminal parser
package asgr_pkg;

	// parser controller states
	typedef enum logic [2:0] {
		ST_NORMAL,
		ST_ESC,
		ST_CSI,
		ST_ARGS,
		ST_SGR
	} state_t;

	// class of the incoming byte
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_BELL,
		CLS_BS,
		CLS_LF,
		CLS_CR,
		CLS_ESC,
		CLS_SILENT,
		CLS_DIGIT,
		CLS_SEMI,
		CLS_LBR,
		CLS_M
	} byte_class_t;

	// cursor and cell action for a byte in normal mode
	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_BELL,
		CUR_BS,
		CUR_LF,
		CUR_CR,
		CUR_PUT
	} cur_op_t;

	// kind of result word
	typedef enum logic [1:0] {
		EV_NONE,
		EV_WRITE,
		EV_CLEAR,
		EV_BELL
	} event_kind_t;

	// controller to datapath
	typedef struct packed {
		logic    out_load;
		cur_op_t cur_op;
		logic    par_clear;
		logic    par_digit;
		logic    par_commit;
		logic    attr_reset;
		logic    walk_init;
		logic    walk_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		byte_class_t cls;
		logic        count_full;
		logic        walk_end;
		logic        out_busy;
	} status_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW = 1'b1;

	localparam logic [7:0] COLUMNS_RESET  = 8'd40;
	localparam logic [7:0] LAST_ROW_RESET = 8'd29;

	// byte codes
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_BEL  = 8'h07;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_DEL  = 8'h7F;

	// colours and parameter limit
	localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
	localparam logic [15:0] COLOR_BLACK = 16'h0000;
	localparam logic [15:0] PARAM_MAX   = 16'hFFFF;

	// attribute decades and units
	localparam logic [15:0] SGR_SMALL_LIMIT   = 16'd110;
	localparam logic [3:0]  SGR_DEC_BASIC     = 4'd0;
	localparam logic [3:0]  SGR_DEC_NORMAL    = 4'd2;
	localparam logic [3:0]  SGR_DEC_FG        = 4'd3;
	localparam logic [3:0]  SGR_DEC_BG        = 4'd4;
	localparam logic [3:0]  SGR_DEC_FG_BRIGHT = 4'd9;
	localparam logic [3:0]  SGR_DEC_BG_BRIGHT = 4'd10;
	localparam logic [3:0]  SGR_DEC_NONE      = 4'd15;
	localparam logic [3:0]  SGR_BRIGHT_SHIFT  = 4'd6;
	localparam logic [3:0]  SGR_U_BOLD        = 4'd1;
	localparam logic [3:0]  SGR_U_EXT         = 4'd8;
	localparam logic [3:0]  SGR_U_DEFAULT     = 4'd9;
	localparam logic [15:0] SGR_EXT_RGB       = 16'd2;

	// rgb565 palettes
	localparam logic [15:0] PAL_BASE [8] = '{
		16'h0000, 16'hA800, 16'h0540, 16'hAAA0,
		16'h0015, 16'hA815, 16'h0555, 16'hAD55
	};
	localparam logic [15:0] PAL_BRIGHT [8] = '{
		16'h52AA, 16'hFAAA, 16'h57EA, 16'hFFEA,
		16'h52BF, 16'hFABF, 16'h57FF, 16'hFFFF
	};

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] units;
	} sgr_split_t;

	// tens and units of a value below 110
	function automatic sgr_split_t sgr_split(input logic [6:0] v);
		sgr_split_t r;
		logic [6:0] rem;
		r.tens = 4'd0;
		for (int k = 1; k <= 10; k++) begin
			if (v >= 7'(10 * k)) r.tens = 4'(k);
		end
		rem = v - 7'({3'b000, r.tens} * 7'd10);
		r.units = rem[3:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/ansi_escape_sgr_terminal_parser_unit.sv =====
// top level of the terminal byte parser with colour attributes
//
//  word     dir  handshake              payload
//  byte     in   in_valid / in_stall    byte_in
//  cell     out  out_valid / out_stall  event_kind, cell_row, cell_col, cell_char,
//                                       cell_fg, cell_bg
//  config   in   cfg_we                 cfg_idx, cfg_wdata
//
// one byte a cycle while in_stall is low; every byte gives one cell word in the
// cycle after it is taken; a byte 'm' ending a list of 1 to MAX_PARAMS parameters
// starts the attribute walk, which reads one parameter store entry a cycle
// reset clears mode, cursor and colours and sets 40 columns, last row 29;
// no clearing pass, the store is refilled by each new list
// the cell word waits in an output register; a new byte is taken in the cycle
// the waiting word leaves, and in_stall is high while out_stall holds a word
module ansi_escape_sgr_terminal_parser_unit #(
	parameter int MAX_PARAMS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [asgr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [asgr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       byte_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       event_kind,
	output logic [7:0]                       cell_row,
	output logic [7:0]                       cell_col,
	output logic [7:0]                       cell_char,
	output logic [15:0]                      cell_fg,
	output logic [15:0]                      cell_bg
);

	asgr_pkg::cmd_t    cmd;
	asgr_pkg::status_t status;

	// controller
	asgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	asgr_dp #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.byte_in    (byte_in),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.event_kind (event_kind),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_char  (cell_char),
		.cell_fg    (cell_fg),
		.cell_bg    (cell_bg)
	);

endmodule

// ===== rtl/core/asgr_ctrl.sv =====
// parser controller: escape sequence state machine and datapath commands
module asgr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  asgr_pkg::status_t  status,
	output asgr_pkg::cmd_t     cmd
);

	asgr_pkg::state_t state_q, state_d;
	logic acc;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asgr_pkg::ST_NORMAL;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = status.out_busy || (state_q == asgr_pkg::ST_SGR);
		acc         = in_valid && !in_stall;
		cmd.out_load = acc;
		unique case (state_q)
			asgr_pkg::ST_NORMAL: begin
				if (acc) begin
					unique case (status.cls)
						asgr_pkg::CLS_BELL:   cmd.cur_op = asgr_pkg::CUR_BELL;
						asgr_pkg::CLS_BS:     cmd.cur_op = asgr_pkg::CUR_BS;
						asgr_pkg::CLS_LF:     cmd.cur_op = asgr_pkg::CUR_LF;
						asgr_pkg::CLS_CR:     cmd.cur_op = asgr_pkg::CUR_CR;
						asgr_pkg::CLS_ESC:    state_d = asgr_pkg::ST_ESC;
						asgr_pkg::CLS_SILENT: cmd.cur_op = asgr_pkg::CUR_NONE;
						default:              cmd.cur_op = asgr_pkg::CUR_PUT;
					endcase
				end
			end
			asgr_pkg::ST_ESC: begin
				if (acc) begin
					state_d = (status.cls == asgr_pkg::CLS_LBR) ?
						asgr_pkg::ST_CSI : asgr_pkg::ST_NORMAL;
				end
			end
			asgr_pkg::ST_CSI: begin
				if (acc) begin
					unique case (status.cls)
						asgr_pkg::CLS_DIGIT: begin
							cmd.par_clear = 1'b1;
							cmd.par_digit = 1'b1;
							state_d       = asgr_pkg::ST_ARGS;
						end
						asgr_pkg::CLS_SEMI: begin
							cmd.par_clear  = 1'b1;
							cmd.par_commit = 1'b1;
							state_d        = asgr_pkg::ST_ARGS;
						end
						asgr_pkg::CLS_M: begin
							cmd.attr_reset = 1'b1;
							state_d        = asgr_pkg::ST_NORMAL;
						end
						default: state_d = asgr_pkg::ST_NORMAL;
					endcase
				end
			end
			asgr_pkg::ST_ARGS: begin
				if (acc) begin
					// list full: the byte is dropped
					if (status.count_full) begin
						state_d = asgr_pkg::ST_NORMAL;
					end else begin
						unique case (status.cls)
							asgr_pkg::CLS_DIGIT: cmd.par_digit  = 1'b1;
							asgr_pkg::CLS_SEMI:  cmd.par_commit = 1'b1;
							asgr_pkg::CLS_M: begin
								cmd.par_commit = 1'b1;
								cmd.walk_init  = 1'b1;
								state_d        = asgr_pkg::ST_SGR;
							end
							default: begin
								cmd.par_commit = 1'b1;
								state_d        = asgr_pkg::ST_NORMAL;
							end
						endcase
					end
				end
			end
			asgr_pkg::ST_SGR: begin
				// one stored parameter a cycle
				cmd.walk_step = 1'b1;
				if (status.walk_end) state_d = asgr_pkg::ST_NORMAL;
			end
			default: state_d = asgr_pkg::ST_NORMAL;
		endcase
	end

endmodule

// ===== rtl/core/asgr_dp.sv =====
// parser datapath: cursor, parameter store, attribute walk and output register
module asgr_dp #(
	parameter int MAX_PARAMS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [asgr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [asgr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [7:0]                         byte_in,
	input  logic                               out_stall,
	input  asgr_pkg::cmd_t                     cmd,
	output asgr_pkg::status_t                  status,
	output logic                               out_valid,
	output logic [1:0]                         event_kind,
	output logic [7:0]                         cell_row,
	output logic [7:0]                         cell_col,
	output logic [7:0]                         cell_char,
	output logic [15:0]                        cell_fg,
	output logic [15:0]                        cell_bg
);

	localparam int IW = $clog2(MAX_PARAMS);
	localparam int CW = $clog2(MAX_PARAMS + 1);

	logic [7:0]              columns_q, last_row_q;
	logic [7:0]              col_q, row_q;
	logic [15:0]             fg_q, bg_q;
	logic                    bright_q;
	logic [CW-1:0]           count_q;
	logic [15:0]             acc_q;
	logic [15:0]             store_q [MAX_PARAMS];
	logic [IW-1:0]           walk_i_q;
	logic                    out_valid_q;
	asgr_pkg::event_kind_t   ev_kind_q;
	logic [7:0]              ev_row_q, ev_col_q, ev_char_q;
	logic [15:0]             ev_fg_q, ev_bg_q;

	asgr_pkg::byte_class_t   cls;
	logic [8:0]              row_inc, col_inc;
	logic [7:0]              nl_row;
	logic                    wrap;
	logic [7:0]              col_d, row_d;
	asgr_pkg::event_kind_t   res_kind;
	logic [7:0]              res_row, res_col, res_char;
	logic [15:0]             res_fg, res_bg;
	logic [CW-1:0]           cnt_base;
	logic [15:0]             acc_base;
	logic [19:0]             acc_x10;
	logic [15:0]             acc_sat;
	logic [15:0]             v;
	logic                    first, rst0;
	logic [15:0]             fg_b, bg_b;
	logic                    br_b;
	asgr_pkg::sgr_split_t    sp;
	logic [3:0]              tens, units, tens_e;
	logic [15:0]             p1, p2, p3, p4;
	logic [15:0]             rgb;
	logic                    ext_rgb;
	logic [15:0]             fg_w, bg_w;
	logic                    br_w, stop;

	// byte decoder
	always_comb begin
		unique case (byte_in) inside
			asgr_pkg::CH_BEL: cls = asgr_pkg::CLS_BELL;
			asgr_pkg::CH_BS:  cls = asgr_pkg::CLS_BS;
			asgr_pkg::CH_LF:  cls = asgr_pkg::CLS_LF;
			asgr_pkg::CH_CR:  cls = asgr_pkg::CLS_CR;
			asgr_pkg::CH_ESC: cls = asgr_pkg::CLS_ESC;
			asgr_pkg::CH_TAB, asgr_pkg::CH_VT, asgr_pkg::CH_FF, asgr_pkg::CH_DEL:
				cls = asgr_pkg::CLS_SILENT;
			[asgr_pkg::CH_ZERO:asgr_pkg::CH_NINE]: cls = asgr_pkg::CLS_DIGIT;
			asgr_pkg::CH_SEMI: cls = asgr_pkg::CLS_SEMI;
			asgr_pkg::CH_LBR:  cls = asgr_pkg::CLS_LBR;
			asgr_pkg::CH_M:    cls = asgr_pkg::CLS_M;
			default:           cls = asgr_pkg::CLS_OTHER;
		endcase
	end

	// cursor movement and result word
	always_comb begin
		row_inc  = {1'b0, row_q} + 9'd1;
		nl_row   = (row_inc > {1'b0, last_row_q}) ? last_row_q : row_inc[7:0];
		col_inc  = {1'b0, col_q} + 9'd1;
		wrap     = (columns_q == 8'd0) || (col_inc >= {1'b0, columns_q});
		col_d    = col_q;
		row_d    = row_q;
		res_kind = asgr_pkg::EV_NONE;
		res_row  = 8'd0;
		res_col  = 8'd0;
		res_char = 8'd0;
		res_fg   = 16'd0;
		res_bg   = 16'd0;
		unique case (cmd.cur_op)
			asgr_pkg::CUR_BELL: res_kind = asgr_pkg::EV_BELL;
			asgr_pkg::CUR_BS: begin
				res_kind = asgr_pkg::EV_CLEAR;
				res_row  = row_q;
				res_col  = col_q;
				if (col_q != 8'd0) col_d = col_q - 8'd1;
			end
			asgr_pkg::CUR_LF: begin
				col_d = 8'd0;
				row_d = nl_row;
			end
			asgr_pkg::CUR_CR: col_d = 8'd0;
			asgr_pkg::CUR_PUT: begin
				res_kind = asgr_pkg::EV_WRITE;
				res_row  = row_q;
				res_col  = col_q;
				res_char = byte_in;
				res_fg   = fg_q;
				res_bg   = bg_q;
				// a nul is drawn but does not move the cursor
				if (byte_in != asgr_pkg::CH_NUL) begin
					if (wrap) begin
						col_d = 8'd0;
						row_d = nl_row;
					end else begin
						col_d = col_inc[7:0];
					end
				end
			end
			default: res_kind = asgr_pkg::EV_NONE;
		endcase
	end

	// decimal accumulator, saturating
	always_comb begin
		cnt_base = cmd.par_clear ? '0 : count_q;
		acc_base = cmd.par_clear ? 16'd0 : acc_q;
		acc_x10  = ({4'b0000, acc_base} << 3) + ({4'b0000, acc_base} << 1)
			+ {16'd0, byte_in[3:0]};
		acc_sat  = (acc_x10 > {4'b0000, asgr_pkg::PARAM_MAX}) ?
			asgr_pkg::PARAM_MAX : acc_x10[15:0];
	end

	// one attribute step on the current store entry
	always_comb begin
		v       = store_q[walk_i_q];
		first   = (walk_i_q == '0);
		rst0    = first && (v == 16'd0);
		fg_b    = rst0 ? asgr_pkg::COLOR_WHITE : fg_q;
		bg_b    = rst0 ? asgr_pkg::COLOR_BLACK : bg_q;
		br_b    = rst0 ? 1'b0 : bright_q;
		sp      = asgr_pkg::sgr_split(v[6:0]);
		tens    = (v < asgr_pkg::SGR_SMALL_LIMIT) ? sp.tens : asgr_pkg::SGR_DEC_NONE;
		units   = sp.units;
		tens_e  = (br_b && (units != asgr_pkg::SGR_U_EXT) &&
			((tens == asgr_pkg::SGR_DEC_FG) || (tens == asgr_pkg::SGR_DEC_BG))) ?
			tens + asgr_pkg::SGR_BRIGHT_SHIFT : tens;
		// entries past the count read as zero
		p1      = (count_q > CW'(1)) ? store_q[1] : 16'd0;
		p2      = (count_q > CW'(2)) ? store_q[2] : 16'd0;
		p3      = (count_q > CW'(3)) ? store_q[3] : 16'd0;
		p4      = (count_q > CW'(4)) ? store_q[4] : 16'd0;
		rgb     = {p2[7:3], p3[7:2], p4[7:3]};
		ext_rgb = first && (p1 == asgr_pkg::SGR_EXT_RGB);
		fg_w    = fg_b;
		bg_w    = bg_b;
		br_w    = br_b;
		stop    = 1'b0;
		case (tens_e) inside
			asgr_pkg::SGR_DEC_BASIC: begin
				if (units == asgr_pkg::SGR_U_BOLD) br_w = 1'b1;
			end
			asgr_pkg::SGR_DEC_NORMAL: begin
				if (units == asgr_pkg::SGR_U_BOLD) br_w = 1'b0;
			end
			asgr_pkg::SGR_DEC_FG, asgr_pkg::SGR_DEC_BG: begin
				if (units == asgr_pkg::SGR_U_EXT) begin
					// extended colour ends the walk
					stop = 1'b1;
					if (ext_rgb) begin
						if (tens_e == asgr_pkg::SGR_DEC_FG) fg_w = rgb;
						else bg_w = rgb;
					end
				end else if (tens_e == asgr_pkg::SGR_DEC_FG) begin
					fg_w = (units == asgr_pkg::SGR_U_DEFAULT) ?
						asgr_pkg::COLOR_WHITE : asgr_pkg::PAL_BASE[units[2:0]];
				end else begin
					bg_w = (units == asgr_pkg::SGR_U_DEFAULT) ?
						asgr_pkg::COLOR_BLACK : asgr_pkg::PAL_BASE[units[2:0]];
				end
			end
			asgr_pkg::SGR_DEC_FG_BRIGHT: begin
				if (units == asgr_pkg::SGR_U_DEFAULT) fg_w = asgr_pkg::COLOR_WHITE;
				else if (units != asgr_pkg::SGR_U_EXT)
					fg_w = asgr_pkg::PAL_BRIGHT[units[2:0]];
			end
			asgr_pkg::SGR_DEC_BG_BRIGHT: begin
				if (units == asgr_pkg::SGR_U_DEFAULT) bg_w = asgr_pkg::COLOR_BLACK;
				else if (units != asgr_pkg::SGR_U_EXT)
					bg_w = asgr_pkg::PAL_BRIGHT[units[2:0]];
			end
			default: stop = 1'b0;
		endcase
	end

	// status to the controller
	always_comb begin
		status.cls        = cls;
		status.count_full = (count_q >= CW'(MAX_PARAMS));
		status.walk_end   = stop || ((CW'(walk_i_q) + CW'(1)) == count_q);
		status.out_busy   = out_valid_q && out_stall;
	end

	// configuration, cursor, parameters and attributes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= asgr_pkg::COLUMNS_RESET;
			last_row_q <= asgr_pkg::LAST_ROW_RESET;
			col_q      <= 8'd0;
			row_q      <= 8'd0;
			fg_q       <= asgr_pkg::COLOR_WHITE;
			bg_q       <= asgr_pkg::COLOR_BLACK;
			bright_q   <= 1'b0;
			count_q    <= '0;
			acc_q      <= 16'd0;
			walk_i_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == asgr_pkg::CFG_COLUMNS) columns_q <= cfg_wdata;
				else last_row_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (cmd.par_digit) begin
				acc_q   <= acc_sat;
				count_q <= cnt_base;
			end else if (cmd.par_commit) begin
				acc_q   <= 16'd0;
				count_q <= cnt_base + CW'(1);
			end else if (cmd.par_clear) begin
				acc_q   <= 16'd0;
				count_q <= '0;
			end
			if (cmd.walk_init) walk_i_q <= '0;
			else if (cmd.walk_step) walk_i_q <= walk_i_q + IW'(1);
			if (cmd.attr_reset) begin
				fg_q     <= asgr_pkg::COLOR_WHITE;
				bg_q     <= asgr_pkg::COLOR_BLACK;
				bright_q <= 1'b0;
			end else if (cmd.walk_step) begin
				fg_q     <= fg_w;
				bg_q     <= bg_w;
				bright_q <= br_w;
			end
		end
	end

	// parameter store
	always_ff @(posedge clk) begin
		if (cmd.par_commit) store_q[cnt_base[IW-1:0]] <= acc_base;
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ev_kind_q <= res_kind;
			ev_row_q  <= res_row;
			ev_col_q  <= res_col;
			ev_char_q <= res_char;
			ev_fg_q   <= res_fg;
			ev_bg_q   <= res_bg;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = ev_kind_q;
	assign cell_row   = ev_row_q;
	assign cell_col   = ev_col_q;
	assign cell_char  = ev_char_q;
	assign cell_fg    = ev_fg_q;
	assign cell_bg    = ev_bg_q;

endmodule
